FILE: rtl/irup_pkg.sv
// shared types, character codes and helper functions for the ident reply parser
package irup_pkg;

  typedef enum logic [1:0] {
    PH_PORTS,
    PH_KEYWORD,
    PH_TYPE,
    PH_USER
  } field_phase_t;

  typedef enum logic [1:0] {
    NUM_BLANKS,
    NUM_SIGN,
    NUM_DIGITS,
    NUM_DONE
  } num_phase_t;

  typedef struct packed {
    num_phase_t phase;
    logic       nonzero;
  } num_state_t;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_AT       = 8'h40;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_TILDE    = 8'h7E;

  localparam logic [2:0] KW_LEN = 3'd6;

  // characters of the keyword USERID
  function automatic logic [7:0] keyword_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h55;
      3'd1:    c = 8'h53;
      3'd2:    c = 8'h45;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h49;
      3'd5:    c = 8'h44;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // one step of an atoi style scan that only tracks whether a digit was nonzero
  function automatic num_state_t num_feed(input num_state_t s, input logic [7:0] c);
    num_state_t r;
    logic       digit;
    r     = s;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (s.phase != NUM_DONE) begin
      if ((s.phase == NUM_BLANKS) && is_blank(c)) begin
        r = s;
      end else if ((s.phase == NUM_BLANKS) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
        r.phase = NUM_SIGN;
      end else if (digit) begin
        r.phase = NUM_DIGITS;
        if (c != CH_ZERO) begin
          r.nonzero = 1'b1;
        end
      end else begin
        r.phase = NUM_DONE;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/irup_front.sv
// front end: parses reply bytes, pushes kept username characters and a per-reply verdict
module irup_front #(
  parameter int USER_MAX = 10,
  parameter int MSG_MAX  = 128,
  parameter int UW       = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          recv_valid,
  output logic          recv_ready,
  input  logic [7:0]    recv_byte,
  input  logic          is_last,
  output logic          char_push,
  output logic [7:0]    char_data,
  input  logic          char_full,
  output logic          desc_valid,
  output logic          desc_ok,
  output logic [UW-1:0] desc_cnt,
  input  logic          desc_full
);

  irup_pkg::field_phase_t phase, phase_next;
  irup_pkg::num_state_t   rem_num, rem_num_next;
  irup_pkg::num_state_t   loc_num, loc_num_next;
  logic                   comma_seen, comma_seen_next;
  logic [2:0]             kw_prog, kw_prog_next;
  logic                   kw_found, kw_found_next;
  logic                   prefix_skipping, prefix_skipping_next;
  logic                   user_stopped, user_stopped_next;
  logic [UW-1:0]          user_count, user_count_next;
  logic [7:0]             bytes_seen, bytes_seen_next;
  logic                   text_ended, text_ended_next;
  logic                   accept;
  logic                   prefix_drop;

  assign recv_ready = !char_full && !desc_full;
  assign accept     = recv_valid && recv_ready;
  assign char_data  = recv_byte;
  assign desc_valid = accept && is_last;

  always_comb begin
    phase_next           = phase;
    rem_num_next         = rem_num;
    loc_num_next         = loc_num;
    comma_seen_next      = comma_seen;
    kw_prog_next         = kw_prog;
    kw_found_next        = kw_found;
    prefix_skipping_next = prefix_skipping;
    user_stopped_next    = user_stopped;
    user_count_next      = user_count;
    bytes_seen_next      = bytes_seen;
    text_ended_next      = text_ended;
    char_push            = 1'b0;
    prefix_drop          = 1'b0;

    if (accept && !text_ended && (bytes_seen < 8'(MSG_MAX))) begin
      bytes_seen_next = bytes_seen + 8'd1;
      if (recv_byte == irup_pkg::CH_NUL) begin
        text_ended_next = 1'b1;
      end else begin
        unique case (phase)
          irup_pkg::PH_PORTS: begin
            if (recv_byte == irup_pkg::CH_COLON) begin
              phase_next = irup_pkg::PH_KEYWORD;
            end else if ((recv_byte == irup_pkg::CH_COMMA) && !comma_seen) begin
              comma_seen_next = 1'b1;
            end else if (!comma_seen) begin
              rem_num_next = irup_pkg::num_feed(rem_num, recv_byte);
            end else begin
              loc_num_next = irup_pkg::num_feed(loc_num, recv_byte);
            end
          end
          irup_pkg::PH_KEYWORD: begin
            if (recv_byte == irup_pkg::CH_COLON) begin
              phase_next = irup_pkg::PH_TYPE;
            end else if (!kw_found) begin
              if (recv_byte == irup_pkg::keyword_char(kw_prog)) begin
                kw_prog_next = kw_prog + 3'd1;
              end else if (recv_byte == irup_pkg::keyword_char(3'd0)) begin
                kw_prog_next = 3'd1;
              end else begin
                kw_prog_next = 3'd0;
              end
              if (kw_prog_next == irup_pkg::KW_LEN) begin
                kw_found_next = 1'b1;
              end
            end
          end
          irup_pkg::PH_TYPE: begin
            if (recv_byte == irup_pkg::CH_COLON) begin
              phase_next = irup_pkg::PH_USER;
            end
          end
          irup_pkg::PH_USER: begin
            if (!user_stopped) begin
              if (prefix_skipping) begin
                if ((recv_byte == irup_pkg::CH_TILDE) || (recv_byte == irup_pkg::CH_CARET)) begin
                  prefix_drop = 1'b1;
                end else begin
                  prefix_skipping_next = 1'b0;
                end
              end
              if (!prefix_drop && (user_count < UW'(USER_MAX))) begin
                if (recv_byte == irup_pkg::CH_AT) begin
                  user_stopped_next = 1'b1;
                end else if (!irup_pkg::is_blank(recv_byte) &&
                             (recv_byte != irup_pkg::CH_COLON) &&
                             (recv_byte != irup_pkg::CH_LBRACKET)) begin
                  char_push       = 1'b1;
                  user_count_next = user_count + UW'(1);
                end
              end
            end
          end
          default: phase_next = phase;
        endcase
      end
    end

    // verdict sees the state after this byte
    desc_ok  = (phase_next == irup_pkg::PH_USER) && comma_seen_next &&
               rem_num_next.nonzero && loc_num_next.nonzero && kw_found_next;
    desc_cnt = user_count_next;

    if (accept && is_last) begin
      phase_next           = irup_pkg::PH_PORTS;
      rem_num_next         = '{phase: irup_pkg::NUM_BLANKS, nonzero: 1'b0};
      loc_num_next         = '{phase: irup_pkg::NUM_BLANKS, nonzero: 1'b0};
      comma_seen_next      = 1'b0;
      kw_prog_next         = 3'd0;
      kw_found_next        = 1'b0;
      prefix_skipping_next = 1'b1;
      user_stopped_next    = 1'b0;
      user_count_next      = '0;
      bytes_seen_next      = 8'd0;
      text_ended_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= irup_pkg::PH_PORTS;
      rem_num         <= '{phase: irup_pkg::NUM_BLANKS, nonzero: 1'b0};
      loc_num         <= '{phase: irup_pkg::NUM_BLANKS, nonzero: 1'b0};
      comma_seen      <= 1'b0;
      kw_prog         <= 3'd0;
      kw_found        <= 1'b0;
      prefix_skipping <= 1'b1;
      user_stopped    <= 1'b0;
      user_count      <= '0;
      bytes_seen      <= 8'd0;
      text_ended      <= 1'b0;
    end else begin
      phase           <= phase_next;
      rem_num         <= rem_num_next;
      loc_num         <= loc_num_next;
      comma_seen      <= comma_seen_next;
      kw_prog         <= kw_prog_next;
      kw_found        <= kw_found_next;
      prefix_skipping <= prefix_skipping_next;
      user_stopped    <= user_stopped_next;
      user_count      <= user_count_next;
      bytes_seen      <= bytes_seen_next;
      text_ended      <= text_ended_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    user_count <= UW'(USER_MAX))
    else $error("username count beyond limit");

  a_push_in_user: assert property (@(posedge clk) disable iff (rst)
    char_push |-> (phase == irup_pkg::PH_USER) && !user_stopped)
    else $error("character kept outside the username field");

  a_kw_found: assert property (@(posedge clk) disable iff (rst)
    (kw_prog == irup_pkg::KW_LEN) |-> kw_found)
    else $error("keyword matched but not flagged");

endmodule

FILE: rtl/irup_cq.sv
// character queue: memory fifo with a registered head word
module irup_cq #(
  parameter int AW = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] push_data,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output logic [7:0] head_data
);

  localparam int DEPTH = 1 << AW;

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          refill;

  assign full   = (count == (AW+1)'(DEPTH));
  assign refill = (count != '0) && (!head_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      head_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (refill) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(push) - (AW+1)'(refill);
      if (refill) begin
        head_valid <= 1'b1;
      end else if (pop) begin
        head_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (refill) begin
      head_data <= mem[rd_ptr];
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full character queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty character queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("character queue count out of range");

endmodule

FILE: rtl/irup_back.sv
// back end: verdict queue, result sequencer and output register
module irup_back #(
  parameter int UW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          desc_valid,
  input  logic          desc_ok,
  input  logic [UW-1:0] desc_cnt,
  output logic          desc_full,
  input  logic          head_valid,
  input  logic [7:0]    head_data,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_ready,
  output logic          ident_ok,
  output logic          has_char,
  output logic [7:0]    user_char,
  output logic          last_result
);

  logic          dq_ok  [2];
  logic [UW-1:0] dq_cnt [2];
  logic          dq_wr;
  logic          dq_rd;
  logic [1:0]    dq_num;
  logic          dq_pop;
  logic          cur_ok;
  logic [UW-1:0] cur_cnt;
  logic [UW-1:0] done, done_next;
  logic          load_ok;
  logic          load;
  logic          ld_ok;
  logic          ld_has;
  logic [7:0]    ld_char;
  logic          ld_last;

  assign desc_full = (dq_num == 2'd2);
  assign cur_ok    = dq_ok[dq_rd];
  assign cur_cnt   = dq_cnt[dq_rd];
  assign load_ok   = !result_valid || result_ready;

  always_comb begin
    pop       = 1'b0;
    dq_pop    = 1'b0;
    load      = 1'b0;
    done_next = done;
    ld_ok     = cur_ok;
    ld_has    = 1'b0;
    ld_char   = irup_pkg::CH_NUL;
    ld_last   = 1'b1;
    if (dq_num != 2'd0) begin
      if (cur_ok && (cur_cnt != '0)) begin
        if (head_valid && load_ok) begin
          pop     = 1'b1;
          load    = 1'b1;
          ld_has  = 1'b1;
          ld_char = head_data;
          ld_last = ((done + UW'(1)) == cur_cnt);
          if (ld_last) begin
            dq_pop    = 1'b1;
            done_next = '0;
          end else begin
            done_next = done + UW'(1);
          end
        end
      end else if (done != cur_cnt) begin
        // rejected reply: drain its characters without a transfer
        if (head_valid) begin
          pop       = 1'b1;
          done_next = done + UW'(1);
        end
      end else if (load_ok) begin
        load      = 1'b1;
        dq_pop    = 1'b1;
        done_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dq_wr        <= 1'b0;
      dq_rd        <= 1'b0;
      dq_num       <= 2'd0;
      done         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (desc_valid) begin
        dq_wr <= !dq_wr;
      end
      if (dq_pop) begin
        dq_rd <= !dq_rd;
      end
      dq_num <= dq_num + 2'(desc_valid) - 2'(dq_pop);
      done   <= done_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid) begin
      dq_ok[dq_wr]  <= desc_ok;
      dq_cnt[dq_wr] <= desc_cnt;
    end
    if (load) begin
      ident_ok    <= ld_ok;
      has_char    <= ld_has;
      user_char   <= ld_char;
      last_result <= ld_last;
    end
  end

  a_dq_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    dq_pop |-> (dq_num != 2'd0))
    else $error("verdict popped from empty queue");

  a_dq_bound: assert property (@(posedge clk) disable iff (rst)
    dq_num <= 2'd2)
    else $error("verdict queue count out of range");

  a_no_char_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !has_char) |-> last_result)
    else $error("result without a character is not the closing one");

  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    (dq_num != 2'd0) |-> (done <= cur_cnt))
    else $error("more characters consumed than the reply holds");

endmodule

FILE: rtl/ident_reply_username_parser.sv
// one received byte is taken per cycle; ready drops only when a queue to the back end is full
// a reply's last byte queues its verdict; its results are then registered at the output
// results leave one per cycle while the sink is ready; rejected characters are only drained
// the character queue memory holds 2**(clog2(USER_MAX)+1) bytes, the verdict queue two replies
// synchronous active-high reset clears parser state, queues and the output valid flag
module ident_reply_username_parser #(
  parameter int USER_MAX = 10,
  parameter int MSG_MAX  = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       recv_valid,
  output logic       recv_ready,
  input  logic [7:0] recv_byte,
  input  logic       is_last,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       ident_ok,
  output logic       has_char,
  output logic [7:0] user_char,
  output logic       last_result
);

  localparam int UW = $clog2(USER_MAX + 1);
  localparam int AW = $clog2(USER_MAX) + 1;

  logic          char_push;
  logic [7:0]    char_data;
  logic          char_full;
  logic          desc_valid;
  logic          desc_ok;
  logic [UW-1:0] desc_cnt;
  logic          desc_full;
  logic          head_valid;
  logic [7:0]    head_data;
  logic          pop;

  irup_front #(
    .USER_MAX (USER_MAX),
    .MSG_MAX  (MSG_MAX),
    .UW       (UW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .recv_valid (recv_valid),
    .recv_ready (recv_ready),
    .recv_byte  (recv_byte),
    .is_last    (is_last),
    .char_push  (char_push),
    .char_data  (char_data),
    .char_full  (char_full),
    .desc_valid (desc_valid),
    .desc_ok    (desc_ok),
    .desc_cnt   (desc_cnt),
    .desc_full  (desc_full)
  );

  irup_cq #(
    .AW (AW)
  ) u_cq (
    .clk        (clk),
    .rst        (rst),
    .push       (char_push),
    .push_data  (char_data),
    .full       (char_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  irup_back #(
    .UW (UW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .desc_valid   (desc_valid),
    .desc_ok      (desc_ok),
    .desc_cnt     (desc_cnt),
    .desc_full    (desc_full),
    .head_valid   (head_valid),
    .head_data    (head_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .ident_ok     (ident_ok),
    .has_char     (has_char),
    .user_char    (user_char),
    .last_result  (last_result)
  );

endmodule

FILE: sim/ident_reply_username_parser_check.sv
// checker for the ident reply parser: predicts the results of each reply and compares transfers
module ident_reply_username_parser_check #(
  parameter int USER_MAX = 10,
  parameter int MSG_MAX  = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       recv_valid,
  input  logic       recv_ready,
  input  logic [7:0] recv_byte,
  input  logic       is_last,
  input  logic       result_valid,
  input  logic       result_ready,
  input  logic       ident_ok,
  input  logic       has_char,
  input  logic [7:0] user_char,
  input  logic       last_result,
  output int         fail_count,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [47:0] KEYWORD = "USERID";

  typedef struct packed {
    logic       ok;
    logic       has_ch;
    logic [7:0] ch;
    logic       fin;
  } name_result_t;

  name_result_t result_q[$];
  int           mismatches;

  // predicted parser state
  irup_pkg::field_phase_t parse_phase;
  logic                   comma_hit;
  irup_pkg::num_phase_t   remote_scan;
  logic                   remote_nz;
  irup_pkg::num_phase_t   local_scan;
  logic                   local_nz;
  int                     kw_pos;
  logic                   kw_hit;
  logic                   prefix_strip;
  logic                   name_stopped;
  logic [7:0]             name_buf[USER_MAX];
  int                     name_len;
  int                     byte_count;
  logic                   text_done;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  function automatic logic blank_char(input logic [7:0] c);
    return (c == irup_pkg::CH_SPACE) || ((c >= irup_pkg::CH_TAB) && (c <= irup_pkg::CH_CR));
  endfunction

  task automatic clear_parse();
    parse_phase  = irup_pkg::PH_PORTS;
    comma_hit    = 1'b0;
    remote_scan  = irup_pkg::NUM_BLANKS;
    remote_nz    = 1'b0;
    local_scan   = irup_pkg::NUM_BLANKS;
    local_nz     = 1'b0;
    kw_pos       = 0;
    kw_hit       = 1'b0;
    prefix_strip = 1'b1;
    name_stopped = 1'b0;
    name_len     = 0;
    byte_count   = 0;
    text_done    = 1'b0;
  endtask

  // atoi style scan, only whether some digit was nonzero matters
  task automatic scan_number(inout irup_pkg::num_phase_t ph, inout logic nz,
                             input logic [7:0] c);
    if (ph == irup_pkg::NUM_DONE) begin
    end else if ((ph == irup_pkg::NUM_BLANKS) && blank_char(c)) begin
    end else if ((ph == irup_pkg::NUM_BLANKS) &&
                 ((c == irup_pkg::CH_PLUS) || (c == irup_pkg::CH_MINUS))) begin
      ph = irup_pkg::NUM_SIGN;
    end else if ((c >= irup_pkg::CH_ZERO) && (c <= irup_pkg::CH_NINE)) begin
      ph = irup_pkg::NUM_DIGITS;
      if (c != irup_pkg::CH_ZERO) nz = 1'b1;
    end else begin
      ph = irup_pkg::NUM_DONE;
    end
  endtask

  task automatic absorb_byte(input logic [7:0] c);
    case (parse_phase)
      irup_pkg::PH_PORTS: begin
        if (c == irup_pkg::CH_COLON) parse_phase = irup_pkg::PH_KEYWORD;
        else if ((c == irup_pkg::CH_COMMA) && !comma_hit) comma_hit = 1'b1;
        else if (!comma_hit) scan_number(remote_scan, remote_nz, c);
        else scan_number(local_scan, local_nz, c);
      end
      irup_pkg::PH_KEYWORD: begin
        if (c == irup_pkg::CH_COLON) begin
          parse_phase = irup_pkg::PH_TYPE;
        end else if (!kw_hit) begin
          if ((kw_pos < 6) && (c == KEYWORD[8*(5-kw_pos) +: 8])) kw_pos++;
          else kw_pos = (c == KEYWORD[47:40]) ? 1 : 0;
          if (kw_pos >= 6) kw_hit = 1'b1;
        end
      end
      irup_pkg::PH_TYPE: begin
        if (c == irup_pkg::CH_COLON) parse_phase = irup_pkg::PH_USER;
      end
      default: begin
        // leading tilde and caret are dropped, anything else ends the prefix
        if (!name_stopped &&
            !(prefix_strip && ((c == irup_pkg::CH_TILDE) || (c == irup_pkg::CH_CARET)))) begin
          prefix_strip = 1'b0;
          if (name_len < USER_MAX) begin
            if (c == irup_pkg::CH_AT) begin
              name_stopped = 1'b1;
            end else if (!blank_char(c) && (c != irup_pkg::CH_COLON) &&
                         (c != irup_pkg::CH_LBRACKET)) begin
              name_buf[name_len] = c;
              name_len++;
            end
          end
        end
      end
    endcase
  endtask

  task automatic close_reply();
    logic ok;
    ok = (parse_phase == irup_pkg::PH_USER) && comma_hit && remote_nz && local_nz && kw_hit;
    if (ok && (name_len > 0)) begin
      for (int k = 0; k < name_len; k++) begin
        result_q.push_back({1'b1, 1'b1, name_buf[k], k == name_len - 1});
      end
    end else begin
      result_q.push_back({ok, 1'b0, 8'h00, 1'b1});
    end
    clear_parse();
  endtask

  always @(posedge clk) begin
    name_result_t want;
    if (rst) begin
      clear_parse();
      result_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result transfer with nothing pending", user_char, 0);
        end else begin
          want = result_q.pop_front();
          if (ident_ok !== want.ok) report_mismatch("ident_ok", ident_ok, want.ok);
          if (has_char !== want.has_ch) report_mismatch("has_char", has_char, want.has_ch);
          if (user_char !== want.ch) report_mismatch("user_char", user_char, want.ch);
          if (last_result !== want.fin) report_mismatch("last_result", last_result, want.fin);
        end
      end
      if (recv_valid && recv_ready) begin
        // text stops at a zero byte or after the length cap
        if (!text_done && (byte_count < MSG_MAX)) begin
          byte_count++;
          if (recv_byte == irup_pkg::CH_NUL) text_done = 1'b1;
          else absorb_byte(recv_byte);
        end
        if (is_last) close_reply();
      end
    end
    fail_count  <= mismatches;
    outstanding <= result_q.size();
  end

endmodule

FILE: sim/ident_reply_username_parser_test.sv
// testbench top for the ident reply parser: reply stimulus, stalling sink and verdict
module ident_reply_username_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 150;
  localparam int LIMIT        = 300000;
  localparam int DRAIN        = 40;

  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_EVERY_FOURTH,
    SINK_SPARSE
  } sink_mode_t;

  logic       clk;
  logic       rst;
  logic       recv_valid;
  logic       recv_ready;
  logic [7:0] recv_byte;
  logic       is_last;
  logic       result_valid;
  logic       result_ready;
  logic       ident_ok;
  logic       has_char;
  logic [7:0] user_char;
  logic       last_result;
  int         fail_count;
  int         outstanding;

  logic [7:0] reply_q[$];
  int         burst_left;
  int         bytes_sent;
  int         cycle_count;
  sink_mode_t sink_mode;
  int         sink_phase;

  ident_reply_username_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .recv_valid   (recv_valid),
    .recv_ready   (recv_ready),
    .recv_byte    (recv_byte),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .ident_ok     (ident_ok),
    .has_char     (has_char),
    .user_char    (user_char),
    .last_result  (last_result)
  );

  ident_reply_username_parser_check u_check (
    .clk          (clk),
    .rst          (rst),
    .recv_valid   (recv_valid),
    .recv_ready   (recv_ready),
    .recv_byte    (recv_byte),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .ident_ok     (ident_ok),
    .has_char     (has_char),
    .user_char    (user_char),
    .last_result  (last_result),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sink stalls follow a mode that is redrawn at random from the sink phase counter
  always @(posedge clk) begin
    if (rst) begin
      sink_mode    <= SINK_OPEN;
      sink_phase   <= 0;
      result_ready <= 1'b0;
    end else begin
      sink_phase <= sink_phase + 1;
      if (sink_phase % 64 == 63) sink_mode <= sink_mode_t'($urandom_range(0, 3));
      case (sink_mode)
        SINK_OPEN:         result_ready <= 1'b1;
        SINK_COIN:         result_ready <= 1'($urandom_range(0, 1));
        SINK_EVERY_FOURTH: result_ready <= (sink_phase % 4 == 0);
        default:           result_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ident_reply_username_parser regression: fail");
    $finish;
  end

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) reply_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? irup_pkg::CH_SPACE :
                                  8'(irup_pkg::CH_TAB + $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] pick_name_char();
    int sel;
    sel = $urandom_range(0, 19);
    case (sel)
      0:       return irup_pkg::CH_TILDE;
      1:       return irup_pkg::CH_CARET;
      2:       return irup_pkg::CH_AT;
      3:       return pick_blank();
      4:       return irup_pkg::CH_COLON;
      5:       return irup_pkg::CH_LBRACKET;
      6:       return 8'($urandom_range(1, 255));
      7:       return 8'($urandom_range(48, 57));
      default: return 8'($urandom_range(97, 122));
    endcase
  endfunction

  task automatic add_number();
    logic all_zero;
    all_zero = ($urandom_range(0, 7) == 0);
    repeat ($urandom_range(0, 2)) reply_q.push_back(pick_blank());
    if ($urandom_range(0, 3) == 0) begin
      reply_q.push_back($urandom_range(0, 1) ? irup_pkg::CH_PLUS : irup_pkg::CH_MINUS);
    end
    repeat (($urandom_range(0, 15) == 0) ? 22 : $urandom_range(1, 5)) begin
      reply_q.push_back(all_zero ? irup_pkg::CH_ZERO :
                                   8'(irup_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
    repeat ($urandom_range(0, 1)) reply_q.push_back(pick_blank());
  endtask

  // mostly well-formed replies with random content, the rest broken or noise
  task automatic build_reply();
    int style;
    style = $urandom_range(0, 19);
    if (style < 2) begin
      repeat ($urandom_range(1, 24)) reply_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      add_number();
      reply_q.push_back(irup_pkg::CH_COMMA);
      add_number();
      if ($urandom_range(0, 9) == 0) add_text(",3");
      reply_q.push_back(irup_pkg::CH_COLON);
      case ($urandom_range(0, 7))
        4:       add_text("UUSERID");
        5:       add_text(" USERI ");
        6:       add_text("USERXUSERID");
        7:       add_text(" ERROR ");
        default: add_text(" USERID ");
      endcase
      if (style != 2) reply_q.push_back(irup_pkg::CH_COLON);
      case ($urandom_range(0, 2))
        0:       add_text(" UNIX ");
        1:       add_text("OTHER");
        default: add_text("X");
      endcase
      // an occasional long type field can push the reply past the length cap
      if ($urandom_range(0, 15) == 0) repeat ($urandom_range(100, 130)) reply_q.push_back("T");
      if (style != 3) reply_q.push_back(irup_pkg::CH_COLON);
      repeat ($urandom_range(0, 3)) begin
        reply_q.push_back($urandom_range(0, 1) ? irup_pkg::CH_TILDE : irup_pkg::CH_CARET);
      end
      repeat ($urandom_range(0, 14)) reply_q.push_back(pick_name_char());
      if (style == 4) reply_q[$urandom_range(0, reply_q.size() - 1)] = irup_pkg::CH_NUL;
      if (style == 5) reply_q[$urandom_range(0, reply_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endtask

  // one transfer; the sender runs in bursts with idle gaps between them
  task automatic put_byte(input logic [7:0] b, input logic l);
    if (burst_left == 0) begin
      recv_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 20);
    end
    burst_left--;
    recv_valid <= 1'b1;
    recv_byte  <= b;
    is_last    <= l;
    @(posedge clk);
    while (!recv_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_reply();
    for (int i = 0; i < reply_q.size(); i++) put_byte(reply_q[i], i == reply_q.size() - 1);
    reply_q.delete();
  endtask

  initial begin
    int random_start;
    rst          = 1'b1;
    recv_valid   = 1'b0;
    recv_byte    = 8'h00;
    is_last      = 1'b0;
    burst_left   = 0;
    bytes_sent   = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    add_text("6193, 23 : USERID : UNIX :stjohns");
    send_reply();
    add_text("1,1:USERID:X:~^~joe@host");
    send_reply();
    add_text("+12 , -7:USERID:UNIX: a b:c[d");
    send_reply();
    add_text("0,23:USERID:UNIX:joe");
    send_reply();
    add_text("5,000:USERID:UNIX:joe");
    send_reply();
    add_text("5,6:ERROR:NO-USER");
    send_reply();
    add_text("5,6:UUSERIX USERID:UNIX:");
    send_reply();
    add_text("5,6:USERID:UNIX:abcdefghijklmnop");
    send_reply();
    add_text("99999999999999999999,1:USERID:OS:big");
    send_reply();
    add_text("5 6,7:USERID:O:x");
    send_reply();
    add_text("5,6,7:USERID:O:~a~b");
    send_reply();
    add_text("5,6:USERID:O:ab");
    reply_q.push_back(irup_pkg::CH_NUL);
    add_text("cd");
    send_reply();
    reply_q.push_back(irup_pkg::CH_TAB);
    reply_q.push_back(8'h0A);
    add_text("5,6:USERID:O:a");
    reply_q.push_back(irup_pkg::CH_TAB);
    add_text("b");
    reply_q.push_back(irup_pkg::CH_CR);
    add_text("c");
    reply_q.push_back(8'h0B);
    send_reply();
    add_text("5,6:USERID:O:~~");
    send_reply();
    add_text("5,6:USERID:O:@joe");
    send_reply();
    add_text("-,6:USERID:O:q");
    send_reply();
    add_text("5,6:USERID:O:abcdefghij@k");
    send_reply();
    // third colon is the last byte that still counts, the rest lies past the cap
    add_text("5,6:USERID:");
    repeat (116) reply_q.push_back("T");
    add_text(":late");
    send_reply();
    reply_q.push_back(8'hFF);
    send_reply();
    reply_q.push_back(irup_pkg::CH_NUL);
    send_reply();

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      build_reply();
      send_reply();
    end

    recv_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("ident_reply_username_parser regression: pass");
    end else begin
      $display("ident_reply_username_parser regression: fail");
    end
    $finish;
  end

endmodule
